@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/stma_pkg.sv @@
// ---------------------------------------------------------------------------
// stma_pkg
// Types and constants of the sparse triplet matrix adder.
// ---------------------------------------------------------------------------
package stma_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 11;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 11;
  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 6;

  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_HDR_A = 3'd0,
    OP_ENT_A = 3'd1,
    OP_HDR_B = 3'd2,
    OP_ENT_B = 3'd3,
    OP_ADD   = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_ERROR
  } state_e;

  typedef struct packed {
    op_e                         op;
    logic [INDEX_BITS-1:0]       row;
    logic [INDEX_BITS-1:0]       col;
    logic signed [VALUE_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        row;
    logic [INDEX_BITS-1:0]        col;
    logic signed [VALUE_BITS-1:0] value;
  } triplet_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ sv/stma_front.sv @@
// ---------------------------------------------------------------------------
// stma_front
// Accepts requests, drops unused op codes and forms queue commands.
// ---------------------------------------------------------------------------
module stma_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stma_pkg::OP_W-1:0]     op_i,
  input  logic [stma_pkg::IDX_W-1:0]    row_i,
  input  logic [stma_pkg::IDX_W-1:0]    col_i,
  input  logic [stma_pkg::VAL_W-1:0]    value_i,
  input  stma_pkg::qstat_t              qstat_i,
  output logic                          push_o,
  output stma_pkg::cmd_t                cmd_o
);

  logic legal;

  always_comb begin
    legal = (op_i == stma_pkg::OP_HDR_A) || (op_i == stma_pkg::OP_ENT_A) ||
            (op_i == stma_pkg::OP_HDR_B) || (op_i == stma_pkg::OP_ENT_B) ||
            (op_i == stma_pkg::OP_ADD);
  end

  assign in_stall_o  = qstat_i.full;
  assign push_o      = in_valid_i && !qstat_i.full && legal;
  assign cmd_o.op    = stma_pkg::op_e'(op_i);
  assign cmd_o.row   = row_i[stma_pkg::INDEX_BITS-1:0];
  assign cmd_o.col   = col_i[stma_pkg::INDEX_BITS-1:0];
  assign cmd_o.value = value_i[stma_pkg::VALUE_BITS-1:0];

endmodule

@@ sv/stma_queue.sv @@
// ---------------------------------------------------------------------------
// stma_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module stma_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stma_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output stma_pkg::cmd_t   cmd_o,
  output stma_pkg::qstat_t qstat_o
);

  stma_pkg::cmd_t                     mem_q [stma_pkg::QUEUE_DEPTH];
  logic [stma_pkg::QADDR_W-1:0]       wr_q, wr_d;
  logic [stma_pkg::QADDR_W-1:0]       rd_q, rd_d;
  logic [stma_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                               do_push;
  logic                               do_pop;

  assign qstat_o.full  = (cnt_q == stma_pkg::QCNT_W'(stma_pkg::QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign cmd_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == stma_pkg::QADDR_W'(stma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == stma_pkg::QADDR_W'(stma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ sv/stma_back.sv @@
// ---------------------------------------------------------------------------
// stma_back
// Holds both triplet stores and dimensions, runs the merge, drives results.
// ---------------------------------------------------------------------------
module stma_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stma_pkg::cmd_t                 cmd_i,
  input  stma_pkg::qstat_t               qstat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [stma_pkg::KIND_W-1:0]    kind_o,
  output logic [stma_pkg::IDX_W-1:0]     row_res_o,
  output logic [stma_pkg::IDX_W-1:0]     col_res_o,
  output logic [stma_pkg::VAL_W-1:0]     value_res_o,
  output logic [stma_pkg::CNT_W-1:0]     count_o,
  output logic                           last_o
);

  localparam int VB = stma_pkg::VALUE_BITS;
  localparam int IB = stma_pkg::INDEX_BITS;

  stma_pkg::triplet_t              a_store_q [stma_pkg::DEPTH];
  stma_pkg::triplet_t              b_store_q [stma_pkg::DEPTH];
  logic [stma_pkg::PTR_W-1:0]      a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [IB-1:0]                   a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [stma_pkg::PTR_W-1:0]      i_q, i_d, j_q, j_d;
  logic [stma_pkg::CNT_W-1:0]      k_q, k_d;
  stma_pkg::state_e                state_q, state_d;

  logic                            out_valid_q;
  stma_pkg::kind_e                 kind_q, kind_d;
  logic [IB-1:0]                   row_q, row_d, col_q, col_d;
  logic signed [VB-1:0]            val_q, val_d;
  logic [stma_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            last_q, last_d;

  logic                            out_free;
  logic                            emit;
  logic                            a_more, b_more;
  stma_pkg::triplet_t              ta, tb;
  logic                            a_lt, b_lt;
  logic signed [VB:0]              sum;
  logic signed [VB-1:0]            sat;
  logic                            dims_ok;
  logic                            wr_a, wr_b;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == stma_pkg::ST_IDLE) && !qstat_i.empty;
  assign a_more   = (i_q < a_cnt_q);
  assign b_more   = (j_q < b_cnt_q);
  assign ta       = a_store_q[i_q[stma_pkg::ADDR_W-1:0]];
  assign tb       = b_store_q[j_q[stma_pkg::ADDR_W-1:0]];
  assign a_lt     = {ta.row, ta.col} < {tb.row, tb.col};
  assign b_lt     = {tb.row, tb.col} < {ta.row, ta.col};
  assign sum      = {ta.value[VB-1], ta.value} + {tb.value[VB-1], tb.value};
  assign dims_ok  = (a_rows_q == b_rows_q) && (a_cols_q == b_cols_q);
  assign wr_a     = pop_o && (cmd_i.op == stma_pkg::OP_ENT_A) &&
                    (a_cnt_q < stma_pkg::PTR_W'(stma_pkg::DEPTH));
  assign wr_b     = pop_o && (cmd_i.op == stma_pkg::OP_ENT_B) &&
                    (b_cnt_q < stma_pkg::PTR_W'(stma_pkg::DEPTH));

  always_comb begin
    if (sum[VB] != sum[VB-1]) begin
      sat = sum[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end else begin
      sat = sum[VB-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stma_pkg::ST_IDLE: begin
        if (pop_o && (cmd_i.op == stma_pkg::OP_ADD)) begin
          state_d = dims_ok ? stma_pkg::ST_MERGE : stma_pkg::ST_ERROR;
        end
      end
      stma_pkg::ST_MERGE: begin
        if (out_free && !a_more && !b_more) begin
          state_d = stma_pkg::ST_IDLE;
        end
      end
      stma_pkg::ST_ERROR: begin
        if (out_free) begin
          state_d = stma_pkg::ST_IDLE;
        end
      end
      default: state_d = stma_pkg::ST_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    emit   = 1'b0;
    kind_d = stma_pkg::KIND_ENTRY;
    row_d  = ta.row;
    col_d  = ta.col;
    val_d  = ta.value;
    cnt_d  = '0;
    last_d = 1'b0;
    case (state_q)
      stma_pkg::ST_IDLE: begin
        if (pop_o && (cmd_i.op == stma_pkg::OP_ADD)) begin
          i_d = '0;
          j_d = '0;
          k_d = '0;
        end
      end
      stma_pkg::ST_MERGE: begin
        if (out_free) begin
          if (a_more && b_more) begin
            if (a_lt) begin
              emit = 1'b1;
              i_d  = i_q + 1'b1;
            end else if (b_lt) begin
              emit  = 1'b1;
              row_d = tb.row;
              col_d = tb.col;
              val_d = tb.value;
              j_d   = j_q + 1'b1;
            end else begin
              emit  = (sat != '0);
              val_d = sat;
              i_d   = i_q + 1'b1;
              j_d   = j_q + 1'b1;
            end
          end else if (a_more) begin
            emit = 1'b1;
            i_d  = i_q + 1'b1;
          end else if (b_more) begin
            emit  = 1'b1;
            row_d = tb.row;
            col_d = tb.col;
            val_d = tb.value;
            j_d   = j_q + 1'b1;
          end else begin
            emit   = 1'b1;
            kind_d = stma_pkg::KIND_SUMMARY;
            row_d  = a_rows_q;
            col_d  = a_cols_q;
            val_d  = '0;
            cnt_d  = k_q;
            last_d = 1'b1;
          end
          if (emit && (kind_d == stma_pkg::KIND_ENTRY)) begin
            k_d = k_q + 1'b1;
          end
        end
      end
      stma_pkg::ST_ERROR: begin
        emit   = out_free;
        kind_d = stma_pkg::KIND_ERROR;
        row_d  = '0;
        col_d  = '0;
        val_d  = '0;
        last_d = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // store loads
  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    if (pop_o) begin
      case (cmd_i.op)
        stma_pkg::OP_HDR_A: a_cnt_d = '0;
        stma_pkg::OP_HDR_B: b_cnt_d = '0;
        stma_pkg::OP_ENT_A: a_cnt_d = wr_a ? a_cnt_q + 1'b1 : a_cnt_q;
        stma_pkg::OP_ENT_B: b_cnt_d = wr_b ? b_cnt_q + 1'b1 : b_cnt_q;
        default: begin
          a_cnt_d = a_cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stma_pkg::ST_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      a_rows_q    <= '0;
      a_cols_q    <= '0;
      b_rows_q    <= '0;
      b_cols_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (pop_o && (cmd_i.op == stma_pkg::OP_HDR_A)) begin
        a_rows_q <= cmd_i.row;
        a_cols_q <= cmd_i.col;
      end
      if (pop_o && (cmd_i.op == stma_pkg::OP_HDR_B)) begin
        b_rows_q <= cmd_i.row;
        b_cols_q <= cmd_i.col;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_store_q[a_cnt_q[stma_pkg::ADDR_W-1:0]] <= '{row: cmd_i.row, col: cmd_i.col,
                                                     value: cmd_i.value};
    end
    if (wr_b) begin
      b_store_q[b_cnt_q[stma_pkg::ADDR_W-1:0]] <= '{row: cmd_i.row, col: cmd_i.col,
                                                     value: cmd_i.value};
    end
    if (emit) begin
      kind_q <= kind_d;
      row_q  <= row_d;
      col_q  <= col_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign row_res_o   = stma_pkg::IDX_W'(row_q);
  assign col_res_o   = stma_pkg::IDX_W'(col_q);
  assign value_res_o = stma_pkg::VAL_W'(val_q);
  assign count_o     = cnt_q;
  assign last_o      = last_q;

endmodule

@@ sv/sparse_triplet_matrix_add.sv @@
// ---------------------------------------------------------------------------
// sparse_triplet_matrix_add
// Adds two sparse matrices held as row-major (row, column, value) lists.
// ---------------------------------------------------------------------------
// Header and entry requests are taken one per cycle while the queue is not
// full; a two-entry command queue sits between the request port and the
// execution side. An add request has its dimensions checked when it is popped,
// then the merge walks both stores and produces at most one result per cycle
// while the result port is not stalled; the result list ends with a summary,
// or is a single mismatch error. No requests are popped from the queue while
// an add is running.
module sparse_triplet_matrix_add (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stma_pkg::OP_W-1:0]     op_i,
  input  logic [stma_pkg::IDX_W-1:0]    row_i,
  input  logic [stma_pkg::IDX_W-1:0]    col_i,
  input  logic [stma_pkg::VAL_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [stma_pkg::KIND_W-1:0]   kind_o,
  output logic [stma_pkg::IDX_W-1:0]    row_res_o,
  output logic [stma_pkg::IDX_W-1:0]    col_res_o,
  output logic [stma_pkg::VAL_W-1:0]    value_res_o,
  output logic [stma_pkg::CNT_W-1:0]    count_o,
  output logic                          last_o
);

  stma_pkg::qstat_t qstat;
  stma_pkg::cmd_t   push_cmd;
  stma_pkg::cmd_t   head_cmd;
  logic             push;
  logic             pop;

  stma_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  stma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  stma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .row_res_o   (row_res_o),
    .col_res_o   (col_res_o),
    .value_res_o (value_res_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/stma_checker.sv @@
// ---------------------------------------------------------------------------
// stma_checker
// Port-level checks on the result channel of the sparse matrix adder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stma_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [stma_pkg::KIND_W-1:0]   kind_o,
  input  logic [stma_pkg::IDX_W-1:0]    row_res_o,
  input  logic [stma_pkg::IDX_W-1:0]    col_res_o,
  input  logic [stma_pkg::VAL_W-1:0]    value_res_o,
  input  logic [stma_pkg::CNT_W-1:0]    count_o,
  input  logic                          last_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(value_res_o) && $stable(last_o),
    "stalled result changed")

  `ASSERT_IMPL(a_err_shape, out_valid_o && (kind_o == stma_pkg::KIND_ERROR),
    last_o && (count_o == '0) && (row_res_o == '0) && (col_res_o == '0) && (value_res_o == '0),
    "malformed mismatch error")

  `ASSERT_IMPL(a_entry_shape, out_valid_o && (kind_o == stma_pkg::KIND_ENTRY),
    !last_o && (count_o == '0),
    "malformed result entry")

  `ASSERT_IMPL(a_sum_shape, out_valid_o && (kind_o == stma_pkg::KIND_SUMMARY),
    last_o && (value_res_o == '0),
    "malformed summary")

endmodule

bind sparse_triplet_matrix_add stma_checker u_stma_checker (.*);

@@ bench/sparse_triplet_matrix_add_tb.sv @@
// ---------------------------------------------------------------------------
// sparse_triplet_matrix_add_tb
// Loads triplet lists into both stores and adds them, with directed cases for
// empty adds, dimension mismatches, saturating and cancelling sums and unused
// opcodes, then overfilled stores and random well-formed and broken matrix
// pairs. A behavioral model predicts every result, and each result is checked
// field by field. The request port idles and the result port stalls at random.
// ---------------------------------------------------------------------------
module sparse_triplet_matrix_add_tb;

  localparam logic [stma_pkg::OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [stma_pkg::OP_W-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [stma_pkg::VAL_W-1:0] VALUE_MAX      = 32'h7fff_ffff;
  localparam logic [stma_pkg::VAL_W-1:0] VALUE_MIN      = 32'h8000_0000;
  localparam int                         MAX_INDEX      = 1024;
  localparam int                         ITEM_TARGET    = 430;
  localparam int                         MAX_WAIT       = 18;
  localparam int                         DRAIN_CYCLES   = 40;
  localparam int                         QUIET_LIMIT    = 4000;

  typedef struct {
    stma_pkg::kind_e                kind;
    logic [stma_pkg::IDX_W-1:0]     row;
    logic [stma_pkg::IDX_W-1:0]     col;
    logic [stma_pkg::VAL_W-1:0]     value;
    logic [stma_pkg::CNT_W-1:0]     count;
    logic                           final_flag;
  } term_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [stma_pkg::OP_W-1:0]     op_i;
  logic [stma_pkg::IDX_W-1:0]    row_i;
  logic [stma_pkg::IDX_W-1:0]    col_i;
  logic [stma_pkg::VAL_W-1:0]    value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [stma_pkg::KIND_W-1:0]   kind_o;
  logic [stma_pkg::IDX_W-1:0]    row_res_o;
  logic [stma_pkg::IDX_W-1:0]    col_res_o;
  logic [stma_pkg::VAL_W-1:0]    value_res_o;
  logic [stma_pkg::CNT_W-1:0]    count_o;
  logic                          last_o;

  stma_pkg::triplet_t            mat_a [stma_pkg::DEPTH];
  stma_pkg::triplet_t            mat_b [stma_pkg::DEPTH];
  int                            len_a;
  int                            len_b;
  logic [stma_pkg::IDX_W-1:0]    rows_a;
  logic [stma_pkg::IDX_W-1:0]    cols_a;
  logic [stma_pkg::IDX_W-1:0]    rows_b;
  logic [stma_pkg::IDX_W-1:0]    cols_b;
  term_t                         merged_terms [$];

  int                 errors;
  int                 requests_sent;
  int                 quiet_cycles;
  bit                 in_calm;
  bit                 out_calm;

  sparse_triplet_matrix_add dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .row_res_o   (row_res_o),
    .col_res_o   (col_res_o),
    .value_res_o (value_res_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [stma_pkg::IDX_W-1:0] draw_index();
    return stma_pkg::IDX_W'($urandom_range(0, MAX_INDEX));
  endfunction

  function automatic logic [stma_pkg::IDX_W-1:0] draw_dim();
    case ($urandom_range(0, 5))
      0: return stma_pkg::IDX_W'($urandom_range(0, 1));
      1: return stma_pkg::IDX_W'(MAX_INDEX);
      2: return draw_index();
      default: return stma_pkg::IDX_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [stma_pkg::VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_term(stma_pkg::kind_e kind, logic [stma_pkg::IDX_W-1:0] row,
                                    logic [stma_pkg::IDX_W-1:0] col,
                                    logic [stma_pkg::VAL_W-1:0] value,
                                    logic [stma_pkg::CNT_W-1:0] count, logic final_flag);
    term_t t;
    t.kind       = kind;
    t.row        = row;
    t.col        = col;
    t.value      = value;
    t.count      = count;
    t.final_flag = final_flag;
    merged_terms.push_back(t);
  endfunction

  function automatic bit key_before(stma_pkg::triplet_t x, stma_pkg::triplet_t y);
    return (x.row < y.row) || (x.row == y.row && x.col < y.col);
  endfunction

  function automatic void track_request(logic [stma_pkg::OP_W-1:0] op,
                                        logic [stma_pkg::IDX_W-1:0] r,
                                        logic [stma_pkg::IDX_W-1:0] c,
                                        logic [stma_pkg::VAL_W-1:0] v);
    int                         ia;
    int                         ib;
    int                         n;
    logic [stma_pkg::VAL_W:0]   wide;
    logic [stma_pkg::VAL_W-1:0] total;
    case (op)
      stma_pkg::OP_HDR_A: begin
        rows_a = r;
        cols_a = c;
        len_a  = 0;
      end
      stma_pkg::OP_HDR_B: begin
        rows_b = r;
        cols_b = c;
        len_b  = 0;
      end
      stma_pkg::OP_ENT_A: begin
        if (len_a < stma_pkg::DEPTH) begin
          mat_a[len_a] = '{row: r, col: c, value: v};
          len_a++;
        end
      end
      stma_pkg::OP_ENT_B: begin
        if (len_b < stma_pkg::DEPTH) begin
          mat_b[len_b] = '{row: r, col: c, value: v};
          len_b++;
        end
      end
      stma_pkg::OP_ADD: begin
        if (rows_a != rows_b || cols_a != cols_b) begin
          push_term(stma_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b1);
          return;
        end
        ia = 0;
        ib = 0;
        n  = 0;
        while (ia < len_a && ib < len_b) begin
          if (key_before(mat_a[ia], mat_b[ib])) begin
            push_term(stma_pkg::KIND_ENTRY, mat_a[ia].row, mat_a[ia].col, mat_a[ia].value,
                      '0, 1'b0);
            ia++;
            n++;
          end else if (key_before(mat_b[ib], mat_a[ia])) begin
            push_term(stma_pkg::KIND_ENTRY, mat_b[ib].row, mat_b[ib].col, mat_b[ib].value,
                      '0, 1'b0);
            ib++;
            n++;
          end else begin
            wide = {mat_a[ia].value[stma_pkg::VAL_W-1], mat_a[ia].value}
                 + {mat_b[ib].value[stma_pkg::VAL_W-1], mat_b[ib].value};
            if (wide[stma_pkg::VAL_W] != wide[stma_pkg::VAL_W-1]) begin
              total = wide[stma_pkg::VAL_W] ? VALUE_MIN : VALUE_MAX;
            end else begin
              total = wide[stma_pkg::VAL_W-1:0];
            end
            if (total != '0) begin
              push_term(stma_pkg::KIND_ENTRY, mat_a[ia].row, mat_a[ia].col, total, '0, 1'b0);
              n++;
            end
            ia++;
            ib++;
          end
        end
        while (ia < len_a) begin
          push_term(stma_pkg::KIND_ENTRY, mat_a[ia].row, mat_a[ia].col, mat_a[ia].value,
                    '0, 1'b0);
          ia++;
          n++;
        end
        while (ib < len_b) begin
          push_term(stma_pkg::KIND_ENTRY, mat_b[ib].row, mat_b[ib].col, mat_b[ib].value,
                    '0, 1'b0);
          ib++;
          n++;
        end
        push_term(stma_pkg::KIND_SUMMARY, rows_a, cols_a, '0, stma_pkg::CNT_W'(n), 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [stma_pkg::VAL_W-1:0] want,
                                      logic [stma_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_request(logic [stma_pkg::OP_W-1:0] op, logic [stma_pkg::IDX_W-1:0] r,
                              logic [stma_pkg::IDX_W-1:0] c, logic [stma_pkg::VAL_W-1:0] v);
    int gap;
    gap = in_calm ? 0 : draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    track_request(op, r, c, v);
    if (op <= stma_pkg::OP_ADD) requests_sent++;
  endtask

  task automatic load_and_add(int n_keys, bit disjoint);
    logic [stma_pkg::IDX_W-1:0] rows;
    logic [stma_pkg::IDX_W-1:0] cols;
    logic [stma_pkg::IDX_W-1:0] rows_other;
    logic [stma_pkg::IDX_W-1:0] cols_other;
    stma_pkg::triplet_t         list_a [$];
    stma_pkg::triplet_t         list_b [$];
    stma_pkg::triplet_t         ta;
    stma_pkg::triplet_t         tb;
    int               width;
    int               span;
    int               stride;
    int               pos;
    int               k;
    int               pick;
    int               ia;
    int               ib;
    rows  = draw_dim();
    cols  = draw_dim();
    width = (cols == 0) ? 1 : cols;
    span  = ((rows == 0) ? 1 : rows) * width;
    stride = span / (n_keys + 1);
    if (stride < 1) stride = 1;
    pos = $urandom_range(0, 2);
    for (k = 0; k < n_keys; k++) begin
      if (pos / width > MAX_INDEX) break;
      ta.row   = stma_pkg::IDX_W'(pos / width);
      ta.col   = stma_pkg::IDX_W'(pos % width);
      ta.value = draw_value();
      tb       = ta;
      tb.value = draw_value();
      pick = disjoint ? $urandom_range(0, 1) : $urandom_range(0, 2);
      if (pick == 2 && $urandom_range(0, 3) == 0) tb.value = -ta.value;
      if (pick != 1) list_a.push_back(ta);
      if (pick != 0) list_b.push_back(tb);
      pos += 1 + $urandom_range(0, stride - 1);
    end
    rows_other = rows;
    cols_other = cols;
    if (!disjoint) begin
      if (list_a.size() >= 2 && $urandom_range(0, 7) == 0) begin
        ia = $urandom_range(0, list_a.size() - 1);
        ib = $urandom_range(0, list_a.size() - 1);
        ta = list_a[ia];
        list_a[ia] = list_a[ib];
        list_a[ib] = ta;
      end
      if (list_b.size() >= 1 && $urandom_range(0, 9) == 0) begin
        ib = $urandom_range(0, list_b.size() - 1);
        list_b.insert(ib, list_b[ib]);
      end
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          rows_other = (rows == '0) ? stma_pkg::IDX_W'(1) : rows - 1'b1;
        end else begin
          cols_other = (cols == stma_pkg::IDX_W'(MAX_INDEX)) ? '0 : cols + 1'b1;
        end
      end
    end
    send_request(stma_pkg::OP_HDR_A, rows, cols, $urandom);
    send_request(stma_pkg::OP_HDR_B, rows_other, cols_other, $urandom);
    ia = 0;
    ib = 0;
    while (ia < list_a.size() || ib < list_b.size()) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request(stma_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                     draw_index(), draw_index(), $urandom);
      end
      if (ib >= list_b.size() || (ia < list_a.size() && $urandom_range(0, 1) == 1)) begin
        send_request(stma_pkg::OP_ENT_A, list_a[ia].row, list_a[ia].col, list_a[ia].value);
        ia++;
      end else begin
        send_request(stma_pkg::OP_ENT_B, list_b[ib].row, list_b[ib].col, list_b[ib].value);
        ib++;
      end
    end
    send_request(stma_pkg::OP_ADD, draw_index(), draw_index(), $urandom);
    if ($urandom_range(0, 5) == 0) begin
      send_request(stma_pkg::OP_ADD, draw_index(), draw_index(), $urandom);
    end
  endtask

  task automatic test_empty_add();
    send_request(stma_pkg::OP_ADD, '0, '0, '0);
  endtask

  task automatic test_dim_mismatch();
    send_request(stma_pkg::OP_HDR_A, 11'd3, 11'd4, $urandom);
    send_request(stma_pkg::OP_HDR_B, 11'd3, 11'd5, $urandom);
    send_request(stma_pkg::OP_ADD, '0, '0, '0);
    send_request(stma_pkg::OP_HDR_B, 11'd4, 11'd4, $urandom);
    send_request(stma_pkg::OP_ADD, '0, '0, '0);
  endtask

  task automatic test_saturation();
    send_request(stma_pkg::OP_HDR_A, stma_pkg::IDX_W'(MAX_INDEX), stma_pkg::IDX_W'(MAX_INDEX),
                 $urandom);
    send_request(stma_pkg::OP_HDR_B, stma_pkg::IDX_W'(MAX_INDEX), stma_pkg::IDX_W'(MAX_INDEX),
                 $urandom);
    send_request(stma_pkg::OP_ENT_A, 11'd0, 11'd0, VALUE_MAX);
    send_request(stma_pkg::OP_ENT_B, 11'd0, 11'd0, 32'd1);
    send_request(stma_pkg::OP_ENT_A, 11'd0, 11'd5, 32'd1);
    send_request(stma_pkg::OP_ENT_B, 11'd0, 11'd5, -32'sd1);
    send_request(stma_pkg::OP_ENT_B, 11'd1, 11'd7, -32'sd2);
    send_request(stma_pkg::OP_ENT_A, 11'd2, 11'd3, -32'sd5);
    send_request(stma_pkg::OP_ENT_B, 11'd2, 11'd3, VALUE_MIN);
    send_request(stma_pkg::OP_ENT_A, stma_pkg::IDX_W'(MAX_INDEX), stma_pkg::IDX_W'(MAX_INDEX),
                 32'd7);
    send_request(stma_pkg::OP_ADD, '0, '0, '0);
  endtask

  task automatic test_unused_ops();
    int code;
    for (code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
      send_request(stma_pkg::OP_W'(code), draw_index(), draw_index(), $urandom);
    end
    send_request(stma_pkg::OP_ADD, stma_pkg::IDX_W'(MAX_INDEX), stma_pkg::IDX_W'(MAX_INDEX),
                 VALUE_MIN);
  endtask

  task automatic test_full_stores();
    int k;
    for (k = 0; k < 3; k++) begin
      in_calm = (k == 1);
      load_and_add(2 * stma_pkg::DEPTH + 8, 1'b1);
    end
  endtask

  task automatic test_random_sums();
    while (requests_sent < ITEM_TARGET) begin
      in_calm = ($urandom_range(0, 3) == 0);
      load_and_add(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24),
                   1'b0);
    end
  endtask

  initial begin : result_port
    int    hold;
    term_t want;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      if (merged_terms.size() == 0) begin
        $error("unexpected result: kind %0h row %0h col %0h value %0h", kind_o, row_res_o,
               col_res_o, value_res_o);
        errors++;
      end else begin
        want = merged_terms.pop_front();
        check_field("kind", stma_pkg::VAL_W'(want.kind), stma_pkg::VAL_W'(kind_o));
        check_field("row_res", stma_pkg::VAL_W'(want.row), stma_pkg::VAL_W'(row_res_o));
        check_field("col_res", stma_pkg::VAL_W'(want.col), stma_pkg::VAL_W'(col_res_o));
        check_field("value_res", want.value, value_res_o);
        check_field("count", stma_pkg::VAL_W'(want.count), stma_pkg::VAL_W'(count_o));
        check_field("last", stma_pkg::VAL_W'(want.final_flag), stma_pkg::VAL_W'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sparse_triplet_matrix_add_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    errors        = 0;
    requests_sent = 0;
    quiet_cycles  = 0;
    in_calm       = 1'b0;
    out_calm      = 1'b0;
    len_a         = 0;
    len_b         = 0;
    rows_a        = '0;
    cols_a        = '0;
    rows_b        = '0;
    cols_b        = '0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= stma_pkg::OP_HDR_A;
    row_i         <= '0;
    col_i         <= '0;
    value_i       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_add();
    test_dim_mismatch();
    test_saturation();
    test_unused_ops();
    test_full_stores();
    test_random_sums();
    in_valid_i <= 1'b0;
    while (merged_terms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && merged_terms.size() == 0) begin
      $display("sparse_triplet_matrix_add_tb OK");
    end else begin
      $display("sparse_triplet_matrix_add_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/stma_pkg.sv
sv/stma_front.sv
sv/stma_queue.sv
sv/stma_back.sv
sv/sparse_triplet_matrix_add.sv
sv/stma_checker.sv
bench/sparse_triplet_matrix_add_tb.sv
